// ===== hdl/frp_pkg.sv =====
package frp_pkg;

  localparam int LINE_BITS   = 32;
  localparam int LENGTH_BITS = 16;
  localparam int CNT_BITS    = 32;

  // parser phases
  localparam logic [2:0] PH_SKIP  = 3'd0;
  localparam logic [2:0] PH_NAME  = 3'd1;
  localparam logic [2:0] PH_BASES = 3'd2;
  localparam logic [2:0] PH_PLUS  = 3'd3;
  localparam logic [2:0] PH_QUAL  = 3'd4;
  localparam logic [2:0] PH_ERROR = 3'd5;
  localparam logic [2:0] PH_ENDED = 3'd6;

  // result kinds
  localparam logic [2:0] KIND_NAME     = 3'd0;
  localparam logic [2:0] KIND_BASE     = 3'd1;
  localparam logic [2:0] KIND_QUAL     = 3'd2;
  localparam logic [2:0] KIND_RECORD   = 3'd3;
  localparam logic [2:0] KIND_STREAM   = 3'd4;
  localparam logic [2:0] KIND_BADSTART = 3'd5;
  localparam logic [2:0] KIND_TRUNC    = 3'd6;

  // register indexes
  localparam logic [1:0] REG_ORIENT    = 2'd0;
  localparam logic [1:0] REG_MAX_READS = 2'd1;
  localparam logic [1:0] REG_MAX_BASES = 2'd2;
  localparam logic [1:0] REG_RESERVE   = 2'd3;

  // characters
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_PRINT_LO = 8'h21;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  typedef struct packed {
    logic [3:0]          orientation_mask;
    logic [CNT_BITS-1:0] max_reads_per_chunk;
    logic [CNT_BITS-1:0] max_bases_per_chunk;
    logic [15:0]         reserve_per_read;
  } cfg_t;

  typedef struct packed {
    logic [2:0]             phase;
    logic [LINE_BITS-1:0]   line_count;
    logic [LENGTH_BITS-1:0] quality_length;
    logic [CNT_BITS-1:0]    chunk_read_count;
    logic [CNT_BITS-1:0]    chunk_base_count;
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [31:0] line_number;
    logic [15:0] record_length;
    logic [31:0] reads_in_chunk;
    logic        chunk_closed;
  } result_t;

endpackage

// ===== hdl/frp_regs.sv =====
module frp_regs import frp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.orientation_mask    <= 4'd1;
      cfg.max_reads_per_chunk <= 32'd1048576;
      cfg.max_bases_per_chunk <= 32'd268435456;
      cfg.reserve_per_read    <= 16'd4096;
    end else if (wr_en) begin
      case (idx)
        REG_ORIENT:    cfg.orientation_mask    <= pwdata[3:0];
        REG_MAX_READS: cfg.max_reads_per_chunk <= pwdata;
        REG_MAX_BASES: cfg.max_bases_per_chunk <= pwdata;
        REG_RESERVE:   cfg.reserve_per_read    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORIENT:    prdata = {28'd0, cfg.orientation_mask};
      REG_MAX_READS: prdata = cfg.max_reads_per_chunk;
      REG_MAX_BASES: prdata = cfg.max_bases_per_chunk;
      REG_RESERVE:   prdata = {16'd0, cfg.reserve_per_read};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/frp_step.sv =====
module frp_step import frp_pkg::*; (
  input  state_t     cur,
  input  cfg_t       cfg,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  output state_t     nxt,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
  localparam logic [CNT_BITS-1:0]    CNT_MAX  = '1;

  logic [2:0]               mult;
  logic [LINE_BITS-1:0]     line_inc;
  logic [LENGTH_BITS+2:0]   base_prod;
  logic [18:0]              reserve_prod;
  logic [CNT_BITS:0]        read_sum;
  logic [CNT_BITS:0]        base_sum;
  logic [CNT_BITS-1:0]      read_sat;
  logic [CNT_BITS-1:0]      base_sat;
  logic                     closed;

  assign mult = 3'(cfg.orientation_mask[0]) + 3'(cfg.orientation_mask[1])
              + 3'(cfg.orientation_mask[2]) + 3'(cfg.orientation_mask[3]);

  assign line_inc = (cur.line_count != LINE_MAX) ? cur.line_count + 1'b1 : cur.line_count;

  // chunk budget after a record
  assign base_prod    = mult * cur.quality_length;
  assign reserve_prod = mult * cfg.reserve_per_read;
  assign read_sum     = {1'b0, cur.chunk_read_count} + (CNT_BITS+1)'(mult);
  assign base_sum     = {1'b0, cur.chunk_base_count} + (CNT_BITS+1)'(base_prod);
  assign read_sat     = read_sum[CNT_BITS] ? CNT_MAX : read_sum[CNT_BITS-1:0];
  assign base_sat     = base_sum[CNT_BITS] ? CNT_MAX : base_sum[CNT_BITS-1:0];
  assign closed = (({1'b0, read_sat} + (CNT_BITS+1)'(mult))
                     > {1'b0, cfg.max_reads_per_chunk})
               || (({1'b0, base_sat} + (CNT_BITS+1)'(reserve_prod))
                     > {1'b0, cfg.max_bases_per_chunk});

  always_comb begin
    nxt                = cur;
    res_valid          = 1'b0;
    res.kind           = KIND_NAME;
    res.value          = 8'd0;
    res.record_length  = 16'd0;
    res.reads_in_chunk = 32'd0;
    res.chunk_closed   = 1'b0;

    if (cur.phase == PH_ERROR || cur.phase == PH_ENDED) begin
      // sticky, nothing more
    end else if (end_of_input) begin
      res_valid = 1'b1;
      if (cur.phase == PH_SKIP) begin
        res.kind             = KIND_STREAM;
        res.reads_in_chunk   = 32'(cur.chunk_read_count);
        res.chunk_closed     = 1'b1;
        nxt.chunk_read_count = '0;
        nxt.chunk_base_count = '0;
        nxt.phase            = PH_ENDED;
      end else begin
        res.kind  = KIND_TRUNC;
        nxt.phase = PH_ERROR;
      end
    end else begin
      case (cur.phase)
        PH_SKIP: begin
          if (data_byte == CH_LF) begin
            nxt.line_count = line_inc;
          end else if (data_byte == CH_AT) begin
            nxt.phase = PH_NAME;
          end else if (data_byte != CH_SPACE) begin
            nxt.phase = PH_ERROR;
            res_valid = 1'b1;
            res.kind  = KIND_BADSTART;
            res.value = data_byte;
          end
        end
        PH_NAME: begin
          if (data_byte inside {CH_LF, CH_NUL}) begin
            nxt.line_count = line_inc;
            nxt.phase      = PH_BASES;
          end else begin
            res_valid = 1'b1;
            res.kind  = KIND_NAME;
            res.value = data_byte;
          end
        end
        PH_BASES: begin
          if (data_byte inside {CH_PLUS, CH_NUL}) begin
            nxt.phase = PH_PLUS;
          end else if (data_byte inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
            res_valid = 1'b1;
            res.kind  = KIND_BASE;
            res.value = data_byte;
          end else if (data_byte == CH_LF) begin
            nxt.line_count = line_inc;
          end
        end
        PH_PLUS: begin
          if (data_byte inside {CH_LF, CH_NUL}) begin
            nxt.line_count     = line_inc;
            nxt.quality_length = '0;
            nxt.phase          = PH_QUAL;
          end
        end
        PH_QUAL: begin
          res_valid = 1'b1;
          if (data_byte inside {CH_LF, CH_NUL}) begin
            nxt.line_count       = line_inc;
            nxt.chunk_read_count = closed ? '0 : read_sat;
            nxt.chunk_base_count = closed ? '0 : base_sat;
            nxt.quality_length   = '0;
            nxt.phase            = PH_SKIP;
            res.kind             = KIND_RECORD;
            res.record_length    = 16'(cur.quality_length);
            res.reads_in_chunk   = 32'(read_sat);
            res.chunk_closed     = closed;
          end else begin
            if (cur.quality_length != LEN_MAX) begin
              nxt.quality_length = cur.quality_length + 1'b1;
            end
            res.kind  = KIND_QUAL;
            res.value = data_byte;
          end
        end
        default: ;
      endcase
    end

    res.line_number = 32'(nxt.line_count);
  end

endmodule

// ===== hdl/fastq_record_parser_core.sv =====
// a result word is registered and appears in the cycle after its byte is taken
// throughput: one byte per cycle unless the output holds the input back
// the output register frees the input side whenever the held word is taken
// reset (rst, synchronous, active high): parser skips whitespace, all counters
// clear, registers return to mask 1, 1048576 reads, 268435456 bases, reserve 4096
module fastq_record_parser_core import frp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] end_of_input
  // parsed words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [7:0] value, [39:8] line_number,
                                 // [55:40] record_length, [87:56] reads_in_chunk
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast,   // chunk_closed
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  logic    res_valid;
  result_t res;
  result_t out_word;
  logic    s_accept;

  frp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // next-state and result decision for the byte at the input
  frp_step u_step (
    .cur          (state),
    .cfg          (cfg),
    .data_byte    (s_tdata),
    .end_of_input (s_tuser[0]),
    .nxt          (state_next),
    .res_valid    (res_valid),
    .res          (res)
  );

  // take a byte whenever the output slot is empty or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // parser state advances on every accepted byte, with or without a result
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase            <= PH_SKIP;
      state.line_count       <= '0;
      state.quality_length   <= '0;
      state.chunk_read_count <= '0;
      state.chunk_base_count <= '0;
    end else if (s_accept) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_accept && res_valid) begin
      out_word <= res;
    end
  end

  assign m_tdata = {out_word.reads_in_chunk, out_word.record_length,
                    out_word.line_number, out_word.value};
  assign m_tuser = out_word.kind;
  assign m_tlast = out_word.chunk_closed;

`ifndef SYNTHESIS
  // once the parser has stopped, no new word is produced
  a_sticky_stop: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_ERROR || state.phase == PH_ENDED) && !m_tvalid |=> !m_tvalid)
    else $error("word produced after error or stream end");

  // only record end or stream end may close a chunk
  a_close_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == KIND_RECORD || m_tuser == KIND_STREAM)
    else $error("chunk closed on a character word");

  // stream end always closes the chunk
  a_stream_closes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_STREAM |-> m_tlast)
    else $error("stream end without chunk close");

  // a closing record end leaves an empty chunk behind
  a_chunk_clear: assert property (@(posedge clk) disable iff (rst)
    s_accept && res_valid && res.kind == KIND_RECORD && res.chunk_closed
      |=> state.chunk_read_count == '0 && state.chunk_base_count == '0)
    else $error("chunk counts not cleared on close");
`endif

endmodule
